@@ rtl/core/hfpi_pkg.sv @@
// ----------------------------------------------------------------------------
// hfpi_pkg
// Shared types, constants and width helpers of the four-point Hermite
// interpolator.
// ----------------------------------------------------------------------------
package hfpi_pkg;

	// Configuration register format (Q1.14, two's complement).
	localparam int REG_BITS       = 16;
	localparam int CFG_INDEX_BITS = 8;

	// Fraction bits of the coefficients and of the tangents.
	localparam int COEF_FRAC = 14;
	localparam int TAN_FRAC  = 4;

	// A coefficient of the form one +/- register needs two bits above the register.
	localparam int COEF_BITS = REG_BITS + 2;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TENSION = 8'd0,
		REG_BIAS    = 8'd1
	} reg_index_t;

	// Tangent shaping settings handed to the tangent units.
	typedef struct packed {
		logic signed [REG_BITS-1:0] tension;
		logic signed [REG_BITS-1:0] bias;
	} coef_t;

	// Width of a tangent in Q.TAN_FRAC for differences of the given width.
	// Weighted sum grows by COEF_BITS + 1, each rounding adds one bit back
	// before the shift takes its fraction bits away.
	function automatic int tan_bits(int diff_bits);
		return diff_bits + 2 * COEF_BITS + 3 - (COEF_FRAC - TAN_FRAC) - (COEF_FRAC + 1);
	endfunction

endpackage

@@ rtl/core/hfpi_if.sv @@
// ----------------------------------------------------------------------------
// hfpi_if
// Beat channels of the interpolator: sample input, result output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface hfpi_in_if #(
	parameter int SAMPLE_BITS   = 16,
	parameter int POSITION_BITS = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [SAMPLE_BITS-1:0]   sample_before;
	logic signed [SAMPLE_BITS-1:0]   sample_left;
	logic signed [SAMPLE_BITS-1:0]   sample_right;
	logic signed [SAMPLE_BITS-1:0]   sample_after;
	logic        [POSITION_BITS-1:0] position;

	modport source (
		output valid, sample_before, sample_left, sample_right, sample_after, position,
		input  ready
	);
	modport sink (
		input  valid, sample_before, sample_left, sample_right, sample_after, position,
		output ready
	);
endinterface

interface hfpi_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink (input valid, value, saturated, output ready);
endinterface

interface hfpi_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [hfpi_pkg::CFG_INDEX_BITS-1:0]    index;
	logic [hfpi_pkg::REG_BITS-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/hfpi_tangent.sv @@
// ----------------------------------------------------------------------------
// hfpi_tangent
// Three-stage tangent unit: biased difference sum, tension scaling, final
// rounding to Q.TAN_FRAC.
// ----------------------------------------------------------------------------
module hfpi_tangent #(
	parameter int DIFF_BITS = 17,
	localparam int M_BITS = hfpi_pkg::tan_bits(DIFF_BITS)
) (
	input  logic                        clk,
	input  logic                        en,
	input  hfpi_pkg::coef_t             coef,
	input  logic signed [DIFF_BITS-1:0] d_first,
	input  logic signed [DIFF_BITS-1:0] d_second,
	output logic signed [M_BITS-1:0]    m
);
	import hfpi_pkg::*;

	localparam int SH1     = COEF_FRAC - TAN_FRAC;
	localparam int SH2     = COEF_FRAC + 1;
	localparam int SUM_W   = DIFF_BITS + COEF_BITS + 1;
	localparam int RND_W   = SUM_W + 1 - SH1;
	localparam int TPROD_W = RND_W + COEF_BITS;

	localparam logic signed [COEF_BITS-1:0] ONE_C = COEF_BITS'(1 << COEF_FRAC);

	logic signed [COEF_BITS-1:0] bias_plus, bias_minus, tens_minus;
	logic signed [SUM_W-1:0]     sum;
	logic signed [SUM_W:0]       sum_half, sum_shift;
	logic signed [TPROD_W:0]     tp_half, tp_shift;
	logic signed [RND_W-1:0]     rnd_s2;
	logic signed [TPROD_W-1:0]   tprod_s3;

	assign bias_plus  = ONE_C + $signed({{(COEF_BITS-REG_BITS){coef.bias[REG_BITS-1]}},
		coef.bias});
	assign bias_minus = ONE_C - $signed({{(COEF_BITS-REG_BITS){coef.bias[REG_BITS-1]}},
		coef.bias});
	assign tens_minus = ONE_C - $signed({{(COEF_BITS-REG_BITS){coef.tension[REG_BITS-1]}},
		coef.tension});

	always_comb begin
		sum       = SUM_W'(d_first * bias_plus) + SUM_W'(d_second * bias_minus);
		sum_half  = $signed({sum[SUM_W-1], sum}) + $signed((SUM_W+1)'(1 << (SH1 - 1)));
		sum_shift = sum_half >>> SH1;
		tp_half   = $signed({tprod_s3[TPROD_W-1], tprod_s3})
			+ $signed((TPROD_W+1)'(1 << (SH2 - 1)));
		tp_shift  = tp_half >>> SH2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s2   <= sum_shift[RND_W-1:0];
			tprod_s3 <= TPROD_W'(rnd_s2 * tens_minus);
			m        <= tp_shift[M_BITS-1:0];
		end
	end

endmodule

@@ rtl/core/hermite_four_point_interpolator.sv @@
// ----------------------------------------------------------------------------
// hermite_four_point_interpolator
// Four-point cubic Hermite interpolator with tension and bias, fixed point.
// ----------------------------------------------------------------------------
// The block takes one beat of four neighbouring samples and a Q0.16-style
// position between the middle two, and returns one beat holding the
// interpolated sample, rounded to nearest and saturated to the sample range,
// with a flag that tells when the clamp was applied. It is a seven-stage
// pipeline: a new beat can be taken on every clock while the output is not
// stalled. A beat enters the first stage when it is accepted and moves
// through the stages to the output register. The depth of the pipeline is
// set by the chain of multiplications (position squared, position cubed,
// tangent weighting, tension scaling, basis products), each of which
// has a register stage of its own. The whole pipeline advances together; when
// the output beat is not taken, every stage holds and the input is not ready,
// so no beat is lost or repeated. Tension and bias live in two configuration
// registers written through the configuration channel, which is always ready;
// they should only be changed while no beat is in flight.
// ----------------------------------------------------------------------------
module hermite_four_point_interpolator #(
	parameter int SAMPLE_BITS   = 16,
	parameter int POSITION_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	hfpi_cfg_if.sink cfg,
	hfpi_in_if.sink  samples,
	hfpi_out_if.source result
);
	import hfpi_pkg::*;

	localparam int S      = SAMPLE_BITS;
	localparam int P      = POSITION_BITS;
	localparam int D_W    = S + 1;              // sample differences
	localparam int M_W    = tan_bits(D_W);      // tangents, Q.TAN_FRAC
	localparam int W_W    = P + 4;              // basis weights, signed
	localparam int ACC_W  = W_W + M_W + 2;      // exact weighted sum
	localparam int ASH    = P + TAN_FRAC;       // fraction bits of the sum
	localparam int R_W    = ACC_W + 1 - ASH;    // rounded result before the clamp

	localparam logic signed [W_W-1:0] ONE_W = W_W'(1 << P);
	localparam logic signed [R_W-1:0] MAX_V = {{(R_W-S+1){1'b0}}, {(S-1){1'b1}}};
	localparam logic signed [R_W-1:0] MIN_V = {{(R_W-S+1){1'b1}}, {(S-1){1'b0}}};

	// Configuration registers.
	coef_t coef_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TENSION: coef_q.tension <= cfg.data;
				REG_BIAS:    coef_q.bias    <= cfg.data;
				default: ;
			endcase
		end
	end

	// One enable for the whole pipeline: it moves whenever the output register
	// is empty or its beat is being taken.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign adv           = !v_s7 || result.ready;
	assign samples.ready = adv;
	assign result.valid  = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: differences, position squared.
	logic signed [D_W-1:0] d01_s1, d12_s1, d23_s1;
	logic signed [S-1:0]   y1_s1, y2_s1, y1_s2, y2_s2, y1_s3, y2_s3, y1_s4, y2_s4;
	logic [P-1:0]          f_s1, f_s2;
	logic [2*P-1:0]        ff_s1;

	// Stages 2 to 4: rounded square, cube, then the basis weights.
	logic [P:0]            f2_s2, f2_s3;
	logic [2*P:0]          f3p_s3;
	logic [P-1:0]          f_delay_s3;
	logic [2*P:0]          ff_half;
	logic [2*P+1:0]        f3_half;
	logic [P+1:0]          f3;
	logic signed [W_W-1:0] f2w, f3w;
	logic signed [W_W-1:0] w0_s4, w1_s4, w2_s4, w3_s4;
	logic signed [M_W-1:0] m0, m1;

	// Stages 5 to 7: products, sum, rounding and clamp.
	logic signed [W_W+S-1:0]   py1_s5, py2_s5;
	logic signed [W_W+M_W-1:0] pm0_s5, pm1_s5;
	logic signed [ACC_W-1:0]   acc_s6;
	logic signed [ACC_W:0]     acc_half, acc_shift;
	logic signed [R_W-1:0]     r;
	logic signed [S-1:0]       value_s7;
	logic                      sat_s7;

	always_comb begin
		ff_half   = {1'b0, ff_s1} + (2*P+1)'(1 << (P - 1));
		f3_half   = {1'b0, f3p_s3} + (2*P+2)'(1 << (P - 1));
		f3        = f3_half[2*P+1:P];
		f2w       = $signed(W_W'(f2_s3));
		f3w       = $signed(W_W'(f3));
		acc_half  = $signed({acc_s6[ACC_W-1], acc_s6}) + $signed((ACC_W+1)'(1 << (ASH - 1)));
		acc_shift = acc_half >>> ASH;
		r         = acc_shift[R_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1
			d01_s1 <= $signed({samples.sample_left[S-1], samples.sample_left})
				- $signed({samples.sample_before[S-1], samples.sample_before});
			d12_s1 <= $signed({samples.sample_right[S-1], samples.sample_right})
				- $signed({samples.sample_left[S-1], samples.sample_left});
			d23_s1 <= $signed({samples.sample_after[S-1], samples.sample_after})
				- $signed({samples.sample_right[S-1], samples.sample_right});
			y1_s1  <= samples.sample_left;
			y2_s1  <= samples.sample_right;
			f_s1   <= samples.position;
			ff_s1  <= samples.position * samples.position;
			// Stage 2
			f2_s2 <= ff_half[2*P:P];
			f_s2  <= f_s1;
			y1_s2 <= y1_s1;
			y2_s2 <= y2_s1;
			// Stage 3
			f3p_s3 <= f2_s2 * f_s2;
			f2_s3  <= f2_s2;
			y1_s3  <= y1_s2;
			y2_s3  <= y2_s2;
			// Stage 4: Hermite basis from f, f squared and f cubed.
			w0_s4 <= W_W'(2 * f3w - 3 * f2w + ONE_W);
			w1_s4 <= W_W'(f3w - 2 * f2w + $signed(W_W'(f_delay_s3)));
			w2_s4 <= f3w - f2w;
			w3_s4 <= W_W'(3 * f2w - 2 * f3w);
			y1_s4 <= y1_s3;
			y2_s4 <= y2_s3;
			// Stage 5
			py1_s5 <= w0_s4 * y1_s4;
			py2_s5 <= w3_s4 * y2_s4;
			pm0_s5 <= w1_s4 * m0;
			pm1_s5 <= w2_s4 * m1;
			// Stage 6: the sample terms carry no tangent fraction bits.
			acc_s6 <= ((ACC_W'(py1_s5) + ACC_W'(py2_s5)) <<< TAN_FRAC)
				+ ACC_W'(pm0_s5) + ACC_W'(pm1_s5);
			// Stage 7: clamp to the sample range.
			if (r > MAX_V) begin
				value_s7 <= MAX_V[S-1:0];
				sat_s7   <= 1'b1;
			end else if (r < MIN_V) begin
				value_s7 <= MIN_V[S-1:0];
				sat_s7   <= 1'b1;
			end else begin
				value_s7 <= r[S-1:0];
				sat_s7   <= 1'b0;
			end
		end
	end

	// The linear term of the second weight needs f itself at stage 4.
	always_ff @(posedge clk) begin
		if (adv) begin
			f_delay_s3 <= f_s2;
		end
	end

	assign result.value     = value_s7;
	assign result.saturated = sat_s7;

	// Tangent units: the first from the segments either side of the left
	// sample, the second from those either side of the right one. Their
	// three stages line up with stages 2 to 4 here.
	hfpi_tangent #(.DIFF_BITS(D_W)) u_tangent_left (
		.clk      (clk),
		.en       (adv),
		.coef     (coef_q),
		.d_first  (d01_s1),
		.d_second (d12_s1),
		.m        (m0)
	);

	hfpi_tangent #(.DIFF_BITS(D_W)) u_tangent_right (
		.clk      (clk),
		.en       (adv),
		.coef     (coef_q),
		.d_first  (d12_s1),
		.d_second (d23_s1),
		.m        (m1)
	);

endmodule
